// File: hdl/ssc_pkg.sv
`default_nettype none

package ssc_pkg;

   localparam int MAX_SUM    = 1023;
   localparam int COUNT_BITS = 32;

   localparam int DEPTH  = MAX_SUM + 1;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int ELEM_W = 10;
   localparam int TGT_W  = 10;
   localparam int OUT_W  = 32;

   // common width for comparing sums, elements and the target
   localparam int CMP_W0 = (IDX_W > ELEM_W) ? IDX_W : ELEM_W;
   localparam int CMP_W  = (CMP_W0 > TGT_W) ? CMP_W0 : TGT_W;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [IDX_W-1:0]      idx_type;

   localparam count_type COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam count_type COUNT_ONE = count_type'(1);

   typedef struct packed {
      logic    shift;
      idx_type inj_pos;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: hdl/ssc_cell.sv
`default_nettype none

module ssc_cell import ssc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire idx_type       cell_index,
   input  wire count_type     cnt_from_next,
   input  wire count_type     dly_from_next,
   input  wire count_type     inject,
   output      count_type     cnt,
   output      count_type     dly
);

   count_type cnt_ff, cnt_in;
   count_type dly_ff, dly_in;

   always_comb begin
      cnt_in = ctrl.shift ? cnt_from_next : cnt_ff;
      dly_in = dly_ff;
      if (ctrl.shift) begin
         // the stream enters the delay line at the cell one short of the element
         dly_in = (cell_index == ctrl.inj_pos) ? inject : dly_from_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= (cell_index == '0) ? COUNT_ONE : '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dly_ff <= dly_in;
   end

   assign cnt = cnt_ff;
   assign dly = dly_ff;

endmodule

`default_nettype wire

// File: hdl/ssc_ctrl.sv
`default_nettype none

module ssc_ctrl import ssc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [ELEM_W-1:0] elem_value,
   input  wire logic              last_elem,
   input  wire logic              csr_wr_en,
   input  wire logic [TGT_W-1:0]  csr_wr_data,
   input  wire count_type         head,
   input  wire count_type         delayed,
   output      logic              busy,
   output      cell_ctrl_type     cell_ctrl,
   output      count_type         feedback,
   output      logic              rsp_valid,
   output      logic [OUT_W-1:0]  rsp_count,
   output      logic              rsp_sat
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   idx_type            s_ff, s_in;
   logic [ELEM_W-1:0]  x_ff;
   logic               last_ff;
   logic [TGT_W-1:0]   target_ff;
   count_type          cap_ff, cap_in;
   logic               sat_ff, sat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic               rsp_sat_ff, rsp_sat_in;

   logic               accept;
   logic               running;
   logic               pass_end;
   logic               in_range;
   logic               target_hit;
   count_type          addend;
   logic [COUNT_BITS:0] sum;
   count_type          sum_sat;
   count_type          new_val;
   logic               hit_max;
   logic               sat_now;
   logic [ELEM_W:0]    x_minus1;
   logic [63:0]        cap_wide;
   logic               clamp;

   always_comb begin
      accept   = start && (state_ff == ST_IDLE);
      running  = (state_ff == ST_RUN);
      pass_end = running && (s_ff == IDX_W'(DEPTH - 1));

      in_range   = (CMP_W'(s_ff) >= CMP_W'(x_ff)) && (CMP_W'(s_ff) <= CMP_W'(target_ff));
      target_hit = (CMP_W'(s_ff) == CMP_W'(target_ff));

      // a zero element doubles the entry; otherwise add the entry x places back
      addend  = (x_ff == '0) ? head : delayed;
      sum     = {1'b0, head} + {1'b0, addend};
      sum_sat = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
      new_val = in_range ? sum_sat : head;
      hit_max = running && in_range && (sum_sat == COUNT_MAX);
      sat_now = sat_ff || hit_max;

      // the last element's pass writes back the empty-set table
      if (last_ff) begin
         feedback = (s_ff == '0) ? COUNT_ONE : '0;
      end else begin
         feedback = new_val;
      end

      x_minus1          = {1'b0, x_ff} - (ELEM_W+1)'(1);
      cell_ctrl.shift   = running;
      cell_ctrl.inj_pos = IDX_W'(x_minus1);

      cap_in = cap_ff;
      if (accept) begin
         cap_in = '0;
      end else if (running && target_hit) begin
         cap_in = new_val;
      end

      sat_in = (pass_end && last_ff) ? 1'b0 : sat_now;

      cap_wide     = 64'(cap_in);
      clamp        = cap_wide > 64'(OUT_W'({OUT_W{1'b1}}));
      rsp_valid_in = pass_end && last_ff;
      rsp_count_in = clamp ? {OUT_W{1'b1}} : cap_wide[OUT_W-1:0];
      rsp_sat_in   = sat_now || clamp;

      state_in = state_ff;
      s_in     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (pass_end) begin
               state_in = ST_IDLE;
            end else begin
               s_in = s_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s_ff         <= '0;
         target_ff    <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s_ff         <= s_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cap_ff <= cap_in;
      if (accept) begin
         x_ff    <= elem_value;
         last_ff <= last_elem;
      end
      if (rsp_valid_in) begin
         rsp_count_ff <= rsp_count_in;
         rsp_sat_ff   <= rsp_sat_in;
      end
   end

   assign busy      = running;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;
   assign rsp_sat   = rsp_sat_ff;

`ifndef NO_ASSERTIONS
   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN) && (s_ff == '0))
      else $error("accepted request did not start a pass");

   a_idle_counter: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (s_ff == '0))
      else $error("sum counter moved while idle");

   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(pass_end && last_ff))
      else $error("result without a finished last pass");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

   a_sat_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !sat_ff)
      else $error("saturation flag not cleared after result");
`endif

endmodule

`default_nettype wire

// File: hdl/subset_sum_counter.sv
`default_nettype none

// subset sum counter: counts subsets of a set of elements that add up to a target
//
// config: csr_wr_en/csr_wr_data write the target sum; write only while idle
// request: start with req_element_value and req_last_element, taken at an edge
//   where start is high and busy is low; busy stays high while the element works
// each element makes one pass over the count table: the table is a ring of
//   MAX_SUM+1 cells that rotates one position per cycle while busy is high; a
//   new request is taken only after busy drops, once the pass is complete
// a companion delay line in the same cells gives the entry x sums back
// on the last element rsp_valid pulses one cycle right as busy drops, carrying
//   rsp_subset_count (saturated) and rsp_count_saturated; the same pass writes
//   the table back to one empty subset, so no extra clearing time is needed
// the receiver cannot stall: each result is shown for exactly one cycle
// reset: table holds one empty subset, target is zero, no result pending

module subset_sum_counter import ssc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output      logic              busy,
   input  wire logic [ELEM_W-1:0] req_element_value,
   input  wire logic              req_last_element,
   input  wire logic              csr_wr_en,
   input  wire logic [TGT_W-1:0]  csr_wr_data,
   output      logic              rsp_valid,
   output      logic [OUT_W-1:0]  rsp_subset_count,
   output      logic              rsp_count_saturated
);

   cell_ctrl_type cell_ctrl;
   count_type     feedback;
   count_type     cnt_q  [DEPTH];
   count_type     dly_q  [DEPTH];
   count_type     cnt_nb [DEPTH];
   count_type     dly_nb [DEPTH];

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         if (i == DEPTH - 1) begin : g_tail
            assign cnt_nb[i] = feedback;
            assign dly_nb[i] = cnt_q[0];
         end else begin : g_body
            assign cnt_nb[i] = cnt_q[i+1];
            assign dly_nb[i] = dly_q[i+1];
         end

         ssc_cell u_cell (
            .clock         (clock),
            .reset         (reset),
            .ctrl          (cell_ctrl),
            .cell_index    (IDX_W'(i)),
            .cnt_from_next (cnt_nb[i]),
            .dly_from_next (dly_nb[i]),
            .inject        (cnt_q[0]),
            .cnt           (cnt_q[i]),
            .dly           (dly_q[i])
         );
      end
   endgenerate

   ssc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .elem_value  (req_element_value),
      .last_elem   (req_last_element),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head        (cnt_q[0]),
      .delayed     (dly_q[0]),
      .busy        (busy),
      .cell_ctrl   (cell_ctrl),
      .feedback    (feedback),
      .rsp_valid   (rsp_valid),
      .rsp_count   (rsp_subset_count),
      .rsp_sat     (rsp_count_saturated)
   );

endmodule

`default_nettype wire
